/* rtl/lvw3d_pkg.sv */
// Package for the 3D line voxel walker: coordinate widths, beat structs and codes.
// No dependencies; imported by every file in the block.
package lvw3d_pkg;

   localparam int COORD_BITS = 16;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int NUM_AXES   = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [DELTA_BITS-1:0] delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      kind_type  kind;
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
   } req_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      last;
   } rsp_type;

endpackage

/* rtl/line_voxel_walker_3d.sv */
// Streams the voxels of a 3D Bresenham line, one voxel per accepted beat.
// Throughput is one beat per cycle while req_stall is low: a start or step beat
// is worked out combinationally from the walk registers and is registered into
// the result register, or into the skid register behind it while the result side stalls.
// That skid register lets the request side keep going for one beat after the
// result side stalls; req_stall rises only while it is occupied. A start beat
// always yields the start point; a step beat yields the next voxel while a line
// is in progress and nothing otherwise. The endpoint carries last.
// Depends on lvw3d_pkg.
module line_voxel_walker_3d
   import lvw3d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // walk state
   logic      active_ff,  active_in;
   coord_type cur_ff      [NUM_AXES];
   coord_type cur_in      [NUM_AXES];
   delta_type abs_ff      [NUM_AXES];
   delta_type abs_in      [NUM_AXES];
   logic [NUM_AXES-1:0] signs_ff, signs_in;
   axis_type  drive_ff,   drive_in;
   coord_type drive_end_ff, drive_end_in;
   err_type   err_a_ff,   err_a_in;
   err_type   err_b_ff,   err_b_in;

   // result register and skid
   logic      rsp_valid_ff,  rsp_valid_in;
   rsp_type   rsp_data_ff,   rsp_data_in;
   logic      skid_valid_ff, skid_valid_in;
   rsp_type   skid_data_ff,  skid_data_in;

   logic      accept;
   logic      produce;
   rsp_type   result;

   // start-path signals
   coord_type st_s [NUM_AXES];
   coord_type st_e [NUM_AXES];
   logic signed [DELTA_BITS-1:0] st_diff [NUM_AXES];
   delta_type st_abs [NUM_AXES];
   logic [NUM_AXES-1:0] st_signs;
   axis_type  st_drive;
   delta_type st_dd, st_da, st_db;
   coord_type st_end;

   // step-path signals
   delta_type sp_dd, sp_da, sp_db;
   logic      ea_ge, eb_ge;
   logic [NUM_AXES-1:0] sp_move;
   coord_type sp_cur [NUM_AXES];
   coord_type sp_drive_new;
   err_type   sp_err_a, sp_err_b;

   assign accept  = req_valid && !req_stall;
   assign produce = accept && (req_data.kind == KIND_START || active_ff);

   // ---- start: deltas, signs, driving axis
   always_comb begin
      st_s[0] = req_data.start_x;
      st_s[1] = req_data.start_y;
      st_s[2] = req_data.start_z;
      st_e[0] = req_data.end_x;
      st_e[1] = req_data.end_y;
      st_e[2] = req_data.end_z;
      for (int i = 0; i < NUM_AXES; i++) begin
         st_diff[i]  = DELTA_BITS'(st_e[i]) - DELTA_BITS'(st_s[i]);
         st_signs[i] = !st_diff[i][DELTA_BITS-1] && (st_diff[i] != '0);
         st_abs[i]   = st_diff[i][DELTA_BITS-1] ? delta_type'(-st_diff[i])
                                                : delta_type'(st_diff[i]);
      end
      if (st_abs[0] >= st_abs[1] && st_abs[0] >= st_abs[2]) begin
         st_drive = AXIS_X;
      end else if (st_abs[1] >= st_abs[2]) begin
         st_drive = AXIS_Y;
      end else begin
         st_drive = AXIS_Z;
      end
      case (st_drive)
         AXIS_X: begin
            st_dd = st_abs[0]; st_da = st_abs[1]; st_db = st_abs[2]; st_end = st_e[0];
         end
         AXIS_Y: begin
            st_dd = st_abs[1]; st_da = st_abs[0]; st_db = st_abs[2]; st_end = st_e[1];
         end
         default: begin
            st_dd = st_abs[2]; st_da = st_abs[0]; st_db = st_abs[1]; st_end = st_e[2];
         end
      endcase
   end

   // ---- step: move driving axis, minor axes where their error is non-negative
   always_comb begin
      ea_ge = !err_a_ff[ERR_BITS-1];
      eb_ge = !err_b_ff[ERR_BITS-1];
      case (drive_ff)
         AXIS_X: begin
            sp_dd = abs_ff[0]; sp_da = abs_ff[1]; sp_db = abs_ff[2];
            sp_move = {eb_ge, ea_ge, 1'b1};
         end
         AXIS_Y: begin
            sp_dd = abs_ff[1]; sp_da = abs_ff[0]; sp_db = abs_ff[2];
            sp_move = {eb_ge, 1'b1, ea_ge};
         end
         default: begin
            sp_dd = abs_ff[2]; sp_da = abs_ff[0]; sp_db = abs_ff[1];
            sp_move = {1'b1, eb_ge, ea_ge};
         end
      endcase
      for (int i = 0; i < NUM_AXES; i++) begin
         if (sp_move[i]) begin
            sp_cur[i] = signs_ff[i] ? cur_ff[i] + coord_type'(1) : cur_ff[i] - coord_type'(1);
         end else begin
            sp_cur[i] = cur_ff[i];
         end
      end
      case (drive_ff)
         AXIS_X:  sp_drive_new = sp_cur[0];
         AXIS_Y:  sp_drive_new = sp_cur[1];
         default: sp_drive_new = sp_cur[2];
      endcase
      sp_err_a = err_a_ff + err_type'({sp_da, 1'b0})
                 - (ea_ge ? err_type'({sp_dd, 1'b0}) : err_type'(0));
      sp_err_b = err_b_ff + err_type'({sp_db, 1'b0})
                 - (eb_ge ? err_type'({sp_dd, 1'b0}) : err_type'(0));
   end

   // ---- next walk state and result
   always_comb begin
      active_in    = active_ff;
      cur_in       = cur_ff;
      abs_in       = abs_ff;
      signs_in     = signs_ff;
      drive_in     = drive_ff;
      drive_end_in = drive_end_ff;
      err_a_in     = err_a_ff;
      err_b_in     = err_b_ff;
      if (accept && req_data.kind == KIND_START) begin
         cur_in       = st_s;
         abs_in       = st_abs;
         signs_in     = st_signs;
         drive_in     = st_drive;
         drive_end_in = st_end;
         err_a_in     = err_type'({st_da, 1'b0}) - err_type'(st_dd);
         err_b_in     = err_type'({st_db, 1'b0}) - err_type'(st_dd);
         active_in    = (st_dd != '0);
      end else if (accept && active_ff) begin
         cur_in    = sp_cur;
         err_a_in  = sp_err_a;
         err_b_in  = sp_err_b;
         active_in = (sp_drive_new != drive_end_ff);
      end
      result.point_x = cur_in[0];
      result.point_y = cur_in[1];
      result.point_z = cur_in[2];
      result.last    = !active_in;
   end

   // ---- result register with skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = produce;
            rsp_data_in  = result;
         end
      end else if (produce) begin
         // result side stalled: park the beat
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         drive_ff      <= AXIS_X;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         drive_ff      <= drive_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      abs_ff       <= abs_in;
      signs_ff     <= signs_in;
      drive_end_ff <= drive_end_in;
      err_a_ff     <= err_a_in;
      err_b_ff     <= err_b_in;
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/lvw3d_checker.sv */
// Port-level checks for the 3D line voxel walker, bound to the top level.
// Depends on lvw3d_pkg and line_voxel_walker_3d.
module lvw3d_checker
   import lvw3d_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // every accepted start beat is followed by a valid result beat in the next cycle
   a_start_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == KIND_START |=> rsp_valid)
      else $error("start beat gave no result");

   // request side only stalls while a result beat is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty result register");

   // nothing comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("beat visible straight after reset");

endmodule

bind line_voxel_walker_3d lvw3d_checker u_lvw3d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* bench/voxel_line_checker.sv */
// Checker for line_voxel_walker_3d: watches both beat channels and keeps its own walk state.
// It predicts each voxel and compares result beats in order. Depends on lvw3d_pkg.
module voxel_line_checker
   import lvw3d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      voxels_pending
);

   bit        walking;
   coord_type pos [NUM_AXES];
   coord_type drive_end;
   axis_type  drive_axis;
   logic [NUM_AXES-1:0] step_up;
   delta_type span [NUM_AXES];
   err_type   err_a;
   err_type   err_b;

   rsp_type expected_voxels [$];
   int      fail_tally = 0;
   int      pending = 0;

   assign mismatches     = fail_tally;
   assign voxels_pending = pending;

   function automatic coord_type nudge(input coord_type c, input logic up);
      return up ? c + coord_type'(1) : c - coord_type'(1);
   endfunction

   // Advances the walk by one beat; returns 1 when the beat yields a voxel.
   function automatic bit next_voxel(input req_type beat, output rsp_type voxel);
      int     first_pt [NUM_AXES];
      int     second_pt [NUM_AXES];
      int     major;
      int     minor_a;
      int     minor_b;
      longint run;
      voxel = '0;
      if (beat.kind == KIND_START) begin
         first_pt  = '{int'(beat.start_x), int'(beat.start_y), int'(beat.start_z)};
         second_pt = '{int'(beat.end_x), int'(beat.end_y), int'(beat.end_z)};
         for (int i = 0; i < NUM_AXES; i++) begin
            pos[i]     = coord_type'(first_pt[i]);
            span[i]    = delta_type'(second_pt[i] > first_pt[i] ?
                                     second_pt[i] - first_pt[i] :
                                     first_pt[i] - second_pt[i]);
            step_up[i] = second_pt[i] > first_pt[i];
         end
         // ties favour X, then Y
         if (span[0] >= span[1] && span[0] >= span[2])
            drive_axis = AXIS_X;
         else if (span[1] >= span[2])
            drive_axis = AXIS_Y;
         else
            drive_axis = AXIS_Z;
         major   = int'(drive_axis);
         minor_a = (drive_axis == AXIS_X) ? 1 : 0;
         minor_b = (drive_axis == AXIS_Z) ? 1 : 2;
         run     = longint'(span[major]);
         err_a   = err_type'(2 * longint'(span[minor_a]) - run);
         err_b   = err_type'(2 * longint'(span[minor_b]) - run);
         drive_end = coord_type'(second_pt[major]);
         walking   = run != 0;
      end else begin
         if (!walking)
            return 1'b0;
         major   = int'(drive_axis);
         minor_a = (drive_axis == AXIS_X) ? 1 : 0;
         minor_b = (drive_axis == AXIS_Z) ? 1 : 2;
         run     = longint'(span[major]);
         pos[major] = nudge(pos[major], step_up[major]);
         if (err_a >= 0) begin
            pos[minor_a] = nudge(pos[minor_a], step_up[minor_a]);
            err_a = err_type'(longint'(err_a) - 2 * run);
         end
         if (err_b >= 0) begin
            pos[minor_b] = nudge(pos[minor_b], step_up[minor_b]);
            err_b = err_type'(longint'(err_b) - 2 * run);
         end
         err_a = err_type'(longint'(err_a) + 2 * longint'(span[minor_a]));
         err_b = err_type'(longint'(err_b) + 2 * longint'(span[minor_b]));
         walking = pos[major] != drive_end;
      end
      voxel.point_x = pos[0];
      voxel.point_y = pos[1];
      voxel.point_z = pos[2];
      voxel.last    = !walking;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type predicted;
      if (reset) begin
         walking    = 1'b0;
         pos        = '{default: '0};
         drive_end  = '0;
         drive_axis = AXIS_X;
         step_up    = '0;
         span       = '{default: '0};
         err_a      = '0;
         err_b      = '0;
         expected_voxels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_voxels.size() == 0) begin
               $error("voxel %0d,%0d,%0d with none expected",
                      rsp_data.point_x, rsp_data.point_y, rsp_data.point_z);
               fail_tally++;
            end else begin
               want = expected_voxels.pop_front();
               if (rsp_data.point_x !== want.point_x) begin
                  $error("point_x: expected %0d, got %0d", want.point_x, rsp_data.point_x);
                  fail_tally++;
               end
               if (rsp_data.point_y !== want.point_y) begin
                  $error("point_y: expected %0d, got %0d", want.point_y, rsp_data.point_y);
                  fail_tally++;
               end
               if (rsp_data.point_z !== want.point_z) begin
                  $error("point_z: expected %0d, got %0d", want.point_z, rsp_data.point_z);
                  fail_tally++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  fail_tally++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (next_voxel(req_data, predicted))
               expected_voxels = {expected_voxels, predicted};
         end
      end
      pending = expected_voxels.size();
   end

endmodule

/* bench/line_voxel_walker_3d_test.sv */
// Top of the line_voxel_walker_3d bench: clock, reset, request and result stimulus, verdict.
// Depends on lvw3d_pkg, line_voxel_walker_3d and voxel_line_checker.
module line_voxel_walker_3d_test;
   import lvw3d_pkg::*;

   // worst quiet stretch is the long hold-off; everything else is a shorter random burst
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 250;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int mismatches;
   int voxels_pending;
   int items_sent = 0;
   int quiet_cycles = 0;
   bit sender_gaps;
   bit receiver_gaps;
   bit hold_off = 1'b0;
   bit hold_done = 1'b0;

   always #10 clock = ~clock;

   line_voxel_walker_3d uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   voxel_line_checker walk_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatches     (mismatches),
      .voxels_pending (voxels_pending)
   );

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic int span_of(input int a, input int b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic req_type step_beat();
      req_type beat;
      beat.kind    = KIND_STEP;
      beat.start_x = rand_coord();
      beat.start_y = rand_coord();
      beat.start_z = rand_coord();
      beat.end_x   = rand_coord();
      beat.end_y   = rand_coord();
      beat.end_z   = rand_coord();
      return beat;
   endfunction

   task automatic offer(input req_type beat);
      @(negedge clock);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   // start beat, then a number of step beats; steps past the endpoint hit an idle walker
   task automatic run_line(input int sx, input int sy, input int sz,
                           input int ex, input int ey, input int ez, input int steps);
      req_type beat;
      beat.kind    = KIND_START;
      beat.start_x = coord_type'(sx);
      beat.start_y = coord_type'(sy);
      beat.start_z = coord_type'(sz);
      beat.end_x   = coord_type'(ex);
      beat.end_y   = coord_type'(ey);
      beat.end_z   = coord_type'(ez);
      offer(beat);
      for (int n = 0; n < steps; n++)
         offer(step_beat());
      items_sent += 1 + steps;
   endtask

   task automatic random_line();
      int s [3];
      int e [3];
      int lim;
      int d;
      int reach;
      int pick;
      int steps;
      bit full;
      pick  = $urandom_range(0, 24);
      full  = pick == 24;
      lim   = pick < 3 ? 200 : 12;
      reach = 0;
      for (int i = 0; i < 3; i++) begin
         s[i] = int'(rand_coord());
         if (full) begin
            e[i] = int'(rand_coord());
         end else begin
            d = int'($urandom_range(0, 2 * lim)) - lim;
            e[i] = (s[i] + d > 32767 || s[i] + d < -32768) ? s[i] - d : s[i] + d;
         end
         if (span_of(s[i], e[i]) > reach) reach = span_of(s[i], e[i]);
      end
      // long random lines are cut short by the next start
      if (full) begin
         steps = $urandom_range(0, 6);
      end else begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            steps = $urandom_range(0, reach);
         else if (pick == 1)
            steps = reach + $urandom_range(1, 2);
         else
            steps = reach;
      end
      run_line(s[0], s[1], s[2], e[0], e[1], e[2], steps);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // step with nothing in progress
      offer(step_beat());
      // single-voxel line, then a step into an idle walker
      run_line(0, 0, 0, 0, 0, 0, 1);
      // corner to corner, abandoned by the next start
      run_line(32767, -32768, 32767, -32768, 32767, -32768, 3);
      run_line(32764, -32767, 0, 32767, -32768, 2, 3);
      // three-way tie drives X; Y/Z tie drives Y; Z drives
      run_line(0, 0, 0, 2, 2, -2, 2);
      run_line(5, 5, 5, 5, 3, 7, 3);
      run_line(-1, 0, 1, 0, -1, 4, 3);

      while (items_sent < 350) random_line();
      hold_off = 1'b1;
      while (items_sent < 500) random_line();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      while (items_sent < 700) random_line();
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      while (items_sent < 1000) random_line();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      while (items_sent < 1150) random_line();

      @(negedge clock);
      req_valid <= 1'b0;
      while (voxels_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
